@@ hdl/lmcb_pkg.sv @@
// lmcb_pkg: shared types, codes and default sizes for the link mailbox bridge
// used by lmcb_ctrl and link_mailbox_channel_bridge_unit; no dependencies
package lmcb_pkg;

  // default sizes, handed down from the top level
  localparam int LMCB_BUFFER_BYTES   = 1024;
  localparam int LMCB_CHANNEL_BYTES  = 256;
  localparam int LMCB_TRANSMIT_LIMIT = 1024;

  // header bytes
  localparam logic [7:0] HDR_SEND_HOST = 8'h15;
  localparam logic [7:0] HDR_SEND_LINK = 8'h25;
  localparam logic [7:0] HDR_TX_REQ    = 8'h13;
  localparam logic [7:0] HDR_INFO_B    = 8'h12;
  localparam logic [7:0] HDR_INFO_A1   = 8'h01;
  localparam logic [7:0] HDR_INFO_A2   = 8'h02;
  localparam logic [7:0] HDR_CLEAR_A   = 8'h12;
  localparam logic [7:0] HDR_CLEAR_B   = 8'h00;
  localparam logic [7:0] HDR_STATUS_A  = 8'h05;
  localparam logic [7:0] HDR_STATUS_B  = 8'h20;

  // reply tags and check seed
  localparam logic [15:0] REPLY_CHECK  = 16'h1101;
  localparam logic [15:0] REPLY_STATUS = 16'h2005;
  localparam logic [15:0] CHECK_INIT   = 16'hFFFF;

  typedef enum logic [1:0] {
    CMD_WORD  = 2'd0,
    CMD_READY = 2'd1,
    CMD_ERROR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_WAIT = 2'd0,
    MODE_RECV = 2'd1,
    MODE_SEND = 2'd2
  } mode_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_WR,
    ST_RFIN,
    ST_RCHK,
    ST_RD,
    ST_RDLAST,
    ST_SFIN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] byte_a;
    logic [7:0] byte_b;
    logic [7:0] byte_c;
    logic [7:0] byte_d;
    logic [7:0] net_result;
    logic [7:0] net_phase;
  } item_t;

  typedef struct packed {
    logic        word_valid;
    logic [31:0] out_word;
    logic        is_last;
    logic        tx_request;
    logic [7:0]  tx_channel;
    logic [10:0] tx_size;
    logic        link_fault;
  } res_t;

endpackage

@@ hdl/lmcb_ram.sv @@
// lmcb_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module lmcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/lmcb_ctrl.sv @@
// lmcb_ctrl: command sequencer, header decode, check word and buffer access
// depends on lmcb_pkg; drives the byte buffer held in lmcb_ram
module lmcb_ctrl import lmcb_pkg::*; #(
  parameter int BUFFER_BYTES   = LMCB_BUFFER_BYTES,
  parameter int CHANNEL_BYTES  = LMCB_CHANNEL_BYTES,
  parameter int TRANSMIT_LIMIT = LMCB_TRANSMIT_LIMIT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  item_t                           item_i,
  input  logic                            res_ready_i,
  output logic                            res_valid_o,
  output res_t                            res_o,
  output logic                            mem_we_o,
  output logic [$clog2(BUFFER_BYTES)-1:0] mem_waddr_o,
  output logic [7:0]                      mem_wdata_o,
  output logic                            mem_re_o,
  output logic [$clog2(BUFFER_BYTES)-1:0] mem_raddr_o,
  input  logic [7:0]                      mem_rdata_i
);

  localparam int MAW      = $clog2(BUFFER_BYTES);
  localparam int ABW      = MAW + 2;
  localparam int CHANNELS = BUFFER_BYTES / CHANNEL_BYTES;

  function automatic res_t check_reply(logic [15:0] chk);
    res_t r;
    r            = '0;
    r.word_valid = 1'b1;
    r.out_word   = {REPLY_CHECK, chk};
    r.is_last    = 1'b1;
    return r;
  endfunction

  state_e         state_q, state_d;
  mode_e          mode_q, mode_d;
  item_t          item_q, item_d;
  logic [ABW-1:0] base_q, base_d;
  logic [15:0]    count_q, count_d;
  logic [ABW-1:0] pos_q, pos_d;
  logic [15:0]    check_q, check_d;
  logic [1:0]     k_q, k_d;
  logic [MAW-1:0] clr_q, clr_d;
  logic [31:0]    word_q, word_d;
  logic           cap_q, cap_d;
  logic           rdok_q, rdok_d;
  res_t           res_q, res_d;
  logic           two_q, two_d;

  logic [15:0]    hdr_count;
  logic [15:0]    hdr_check;
  logic           chan_ok;
  logic           count_ok;
  logic [ABW-1:0] hdr_base;
  logic [31:0]    tx_sum;
  logic [ABW-1:0] byte_addr;
  logic           addr_ok;
  logic [ABW-1:0] pos_next;
  logic           done;
  logic [7:0]     cap_byte;
  logic [7:0]     wr_byte;

  assign hdr_count = {item_q.byte_d, item_q.byte_c};
  assign hdr_check = CHECK_INIT ^ {item_q.byte_b, item_q.byte_a} ^ hdr_count;
  assign chan_ok   = 32'(item_q.byte_a) < 32'(CHANNELS);
  assign count_ok  = (hdr_count != 16'd0) && (32'(hdr_count) <= 32'(BUFFER_BYTES));
  assign hdr_base  = ABW'(32'(item_q.byte_a) * 32'(CHANNEL_BYTES));
  assign tx_sum    = 32'(hdr_count) + 32'(item_q.byte_a) * 32'(CHANNEL_BYTES);
  assign byte_addr = base_q + pos_q + ABW'(k_q);
  assign addr_ok   = byte_addr < ABW'(BUFFER_BYTES);
  assign pos_next  = pos_q + ABW'(4);
  assign done      = 32'(pos_next) >= 32'(count_q);
  // bytes beyond the buffer read as zero
  assign cap_byte  = rdok_q ? mem_rdata_i : 8'd0;

  always_comb begin
    case (k_q)
      2'd0:    wr_byte = item_q.byte_a;
      2'd1:    wr_byte = item_q.byte_b;
      2'd2:    wr_byte = item_q.byte_c;
      default: wr_byte = item_q.byte_d;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == MAW'(BUFFER_BYTES - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
        if (item_q.cmd == CMD_ERROR) begin
          if (mode_q != MODE_WAIT) state_d = ST_EMIT;
        end else if (item_q.cmd == CMD_NONE) begin
          state_d = ST_IDLE;
        end else if (mode_q == MODE_RECV) begin
          if (item_q.cmd == CMD_WORD) state_d = ST_WR;
        end else if (mode_q == MODE_SEND) begin
          if (item_q.cmd == CMD_READY) state_d = ST_RD;
        end else if (item_q.cmd == CMD_WORD) begin
          if ((item_q.byte_b == HDR_SEND_HOST || item_q.byte_b == HDR_SEND_LINK) && chan_ok) begin
            state_d = ST_IDLE;
          end else if (item_q.byte_a == HDR_CLEAR_A && item_q.byte_b == HDR_CLEAR_B) begin
            state_d = ST_CLEAR;
          end else if (item_q.byte_b == HDR_INFO_B &&
                       (item_q.byte_a == HDR_INFO_A1 || item_q.byte_a == HDR_INFO_A2)) begin
            state_d = ST_EMIT;
          end else if (item_q.byte_b == HDR_TX_REQ && chan_ok) begin
            state_d = ST_EMIT;
          end else if (item_q.byte_a == HDR_STATUS_A && item_q.byte_b == HDR_STATUS_B) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_WR: begin
        if (k_q == 2'd3) state_d = ST_RFIN;
      end
      ST_RFIN: begin
        state_d = done ? ST_RCHK : ST_IDLE;
      end
      ST_RCHK: begin
        state_d = (mem_rdata_i != 8'd0) ? ST_EMIT : ST_IDLE;
      end
      ST_RD: begin
        if (k_q == 2'd3) state_d = ST_RDLAST;
      end
      ST_RDLAST: begin
        state_d = ST_SFIN;
      end
      ST_SFIN: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (res_ready_i && !two_q) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = byte_addr[MAW-1:0];
    mem_wdata_o = wr_byte;
    mem_re_o    = 1'b0;
    mem_raddr_o = byte_addr[MAW-1:0];
    case (state_q)
      ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        mem_wdata_o = 8'd0;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_WR: begin
        mem_we_o = addr_ok;
      end
      ST_RFIN: begin
        // first byte of the channel decides whether the check is returned
        mem_re_o    = done;
        mem_raddr_o = base_q[MAW-1:0];
      end
      ST_RD: begin
        mem_re_o = addr_ok;
      end
      ST_EMIT: begin
        res_valid_o = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  assign res_o = res_q;

  // datapath registers
  always_comb begin
    mode_d  = mode_q;
    item_d  = item_q;
    base_d  = base_q;
    count_d = count_q;
    pos_d   = pos_q;
    check_d = check_q;
    k_d     = k_q;
    clr_d   = clr_q;
    word_d  = word_q;
    cap_d   = 1'b0;
    rdok_d  = addr_ok;
    res_d   = res_q;
    two_d   = two_q;
    if (cap_q) word_d = {word_q[23:0], cap_byte};
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + MAW'(1);
      end
      ST_IDLE: begin
        if (in_valid_i) item_d = item_i;
      end
      ST_EXEC: begin
        k_d   = 2'd0;
        clr_d = '0;
        two_d = 1'b0;
        if (item_q.cmd == CMD_ERROR) begin
          mode_d           = MODE_WAIT;
          res_d            = '0;
          res_d.is_last    = 1'b1;
          res_d.link_fault = 1'b1;
        end else if (item_q.cmd == CMD_WORD && mode_q == MODE_WAIT) begin
          if ((item_q.byte_b == HDR_SEND_HOST || item_q.byte_b == HDR_SEND_LINK) && chan_ok) begin
            if (count_ok) begin
              count_d = hdr_count;
              base_d  = hdr_base;
              pos_d   = '0;
              if (item_q.byte_b == HDR_SEND_HOST) begin
                check_d = hdr_check;
                mode_d  = MODE_RECV;
              end else begin
                check_d = CHECK_INIT;
                mode_d  = MODE_SEND;
              end
            end
          end else if (item_q.byte_a == HDR_CLEAR_A && item_q.byte_b == HDR_CLEAR_B) begin
            clr_d = '0;
          end else if (item_q.byte_b == HDR_INFO_B &&
                       (item_q.byte_a == HDR_INFO_A1 || item_q.byte_a == HDR_INFO_A2)) begin
            check_d = hdr_check;
            res_d   = check_reply(hdr_check);
          end else if (item_q.byte_b == HDR_TX_REQ && chan_ok) begin
            check_d          = hdr_check;
            res_d            = check_reply(hdr_check);
            res_d.tx_request = 1'b1;
            if (tx_sum > 32'(TRANSMIT_LIMIT)) begin
              res_d.tx_channel = 8'd0;
              res_d.tx_size    = 11'(TRANSMIT_LIMIT);
            end else begin
              res_d.tx_channel = item_q.byte_a;
              res_d.tx_size    = 11'(hdr_count);
            end
          end else if (item_q.byte_a == HDR_STATUS_A && item_q.byte_b == HDR_STATUS_B) begin
            res_d          = '0;
            res_d.word_valid = 1'b1;
            res_d.is_last  = 1'b1;
            res_d.out_word = {REPLY_STATUS, item_q.net_phase, item_q.net_result};
          end
        end
      end
      ST_WR: begin
        k_d = k_q + 2'd1;
      end
      ST_RFIN: begin
        check_d = check_q ^ {item_q.byte_b, item_q.byte_a} ^ {item_q.byte_d, item_q.byte_c};
        pos_d   = pos_next;
        if (done) mode_d = MODE_WAIT;
      end
      ST_RCHK: begin
        res_d = check_reply(check_q);
      end
      ST_RD: begin
        k_d   = k_q + 2'd1;
        cap_d = 1'b1;
      end
      ST_SFIN: begin
        // halfwords of the big-endian word: byte0|byte1<<8 and byte2|byte3<<8
        check_d = check_q ^ {word_q[23:16], word_q[31:24]} ^ {word_q[7:0], word_q[15:8]};
        pos_d   = pos_next;
        res_d            = '0;
        res_d.word_valid = 1'b1;
        res_d.out_word   = word_q;
        res_d.is_last    = !done;
        if (done) begin
          mode_d = MODE_WAIT;
          two_d  = 1'b1;
        end
      end
      ST_EMIT: begin
        if (res_ready_i && two_q) begin
          res_d = check_reply(check_q);
          two_d = 1'b0;
        end
      end
      default: begin
        two_d = two_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      mode_q  <= MODE_WAIT;
      base_q  <= '0;
      count_q <= '0;
      pos_q   <= '0;
      check_q <= CHECK_INIT;
      k_q     <= '0;
      clr_q   <= '0;
      cap_q   <= 1'b0;
      rdok_q  <= 1'b0;
      two_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      base_q  <= base_d;
      count_q <= count_d;
      pos_q   <= pos_d;
      check_q <= check_d;
      k_q     <= k_d;
      clr_q   <= clr_d;
      cap_q   <= cap_d;
      rdok_q  <= rdok_d;
      two_q   <= two_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    word_q <= word_d;
    res_q  <= res_d;
  end

endmodule

@@ hdl/link_mailbox_channel_bridge_unit.sv @@
// channel   dir  tdata (low bit up)                          tuser / tlast
// s_axis    in   byte_a, byte_b, byte_c, byte_d, net_result,  tuser: command
//                net_phase (48 bits)
// m_axis    out  out_word, tx_channel, tx_size, 5 zero bits   tuser: word_valid,
//                (56 bits)                                    tx_request, link_fault;
//                                                             tlast: is_last
// one word at a time: a received payload word is written as four byte accesses
// to the buffer RAM, and the word that completes the count also reads the first
// byte of the channel; a send poll reads four bytes before its word is handed
// out, since the buffer RAM ports are one byte wide (four per link word)
// after reset and after a clear command the buffer is zeroed one byte a
// cycle over all BUFFER_BYTES bytes, with s_axis_tready_o low
// the output register lets the next word in while a result waits on m_axis
// reset: rst_ni asynchronous, active low
// depends on lmcb_pkg, lmcb_ram, lmcb_ctrl
module link_mailbox_channel_bridge_unit import lmcb_pkg::*; #(
  parameter int BUFFER_BYTES   = LMCB_BUFFER_BYTES,
  parameter int CHANNEL_BYTES  = LMCB_CHANNEL_BYTES,
  parameter int TRANSMIT_LIMIT = LMCB_TRANSMIT_LIMIT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // byte_a, byte_b, byte_c, byte_d, net_result, net_phase
  input  logic [47:0] s_axis_tdata_i,
  // command
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // out_word, tx_channel, tx_size, zero fill
  output logic [55:0] m_axis_tdata_o,
  // word_valid, tx_request, link_fault
  output logic [2:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o
);

  localparam int MAW = $clog2(BUFFER_BYTES);

  item_t          item;
  res_t           res;
  logic           res_valid;
  logic           res_ready;
  logic           mem_we;
  logic [MAW-1:0] mem_waddr;
  logic [7:0]     mem_wdata;
  logic           mem_re;
  logic [MAW-1:0] mem_raddr;
  logic [7:0]     mem_rdata;
  logic           out_valid_q, out_valid_d;
  res_t           out_q, out_d;

  assign item.cmd        = cmd_e'(s_axis_tuser_i);
  assign item.byte_a     = s_axis_tdata_i[7:0];
  assign item.byte_b     = s_axis_tdata_i[15:8];
  assign item.byte_c     = s_axis_tdata_i[23:16];
  assign item.byte_d     = s_axis_tdata_i[31:24];
  assign item.net_result = s_axis_tdata_i[39:32];
  assign item.net_phase  = s_axis_tdata_i[47:40];

  lmcb_ctrl #(
    .BUFFER_BYTES  (BUFFER_BYTES),
    .CHANNEL_BYTES (CHANNEL_BYTES),
    .TRANSMIT_LIMIT(TRANSMIT_LIMIT)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .item_i     (item),
    .res_ready_i(res_ready),
    .res_valid_o(res_valid),
    .res_o      (res),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_re_o   (mem_re),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

  lmcb_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_BYTES)
  ) u_buf (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // output register: free when empty or drained this cycle
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_q.tx_size, out_q.tx_channel, out_q.out_word};
  assign m_axis_tuser_o  = {out_q.link_fault, out_q.tx_request, out_q.word_valid};
  assign m_axis_tlast_o  = out_q.is_last;

  // a result offered to the output register holds until it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("pending result changed before it was taken");

  // no new word is taken while a result is still being handed out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !res_valid)
    else $error("input ready while a result is pending");

  // an abort carries no word and no transmit request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[2] |-> !m_axis_tuser_o[0] && !m_axis_tuser_o[1])
    else $error("link fault result carries a word");

  // a transmit request rides on a check reply that closes the word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1] |-> m_axis_tuser_o[0] && m_axis_tlast_o)
    else $error("transmit request without its check reply");

endmodule
